// ----- hw/rtl/ppp_pkg.sv -----
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, codes, side-band types and helpers of the point projector.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int CW   = 32;
  localparam int FB   = 16;
  localparam int RW   = 16;
  localparam int AW   = 12;
  localparam int STEP = 4;

  localparam int DIVB_NW = CW + FB;
  localparam int DIVC_NW = 2 * CW;
  localparam int TW      = CW + 3;
  localparam int TMW     = CW + 2;
  localparam int DIVD_NW = TMW + AW;
  localparam int DIVD_DW = CW + 1;
  localparam int DIVD_QW = RW + 4;

  localparam logic [CW-1:0] Q_ONE = CW'(64'd1 << FB);

  localparam logic FUNC_COEF  = 1'b0;
  localparam logic FUNC_POINT = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_W_ZERO     = 2'd1;
  localparam logic [1:0] ST_DEPTH_ZERO = 2'd2;
  localparam logic [1:0] ST_SAT        = 2'd3;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_DIST   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_CANV_W = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_CANV_H = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_AREA_W = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_AREA_H = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_WIN_W  = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_WIN_H  = 3'd6;

  localparam logic [CW-1:0] RST_DIST   = 32'd3164011;
  localparam logic [CW-1:0] RST_CANV_W = 32'd5242880;
  localparam logic [CW-1:0] RST_CANV_H = 32'd2621440;
  localparam logic [AW-1:0] RST_AREA_W = 12'd640;
  localparam logic [AW-1:0] RST_AREA_H = 12'd480;
  localparam logic [AW-1:0] RST_WIN_W  = 12'd800;
  localparam logic [AW-1:0] RST_WIN_H  = 12'd600;

  typedef struct packed {
    logic wz;
    logic dz;
    logic ovf;
  } flags_t;

  typedef struct packed {
    flags_t     fl;
    logic [2:0] neg;
  } tri_side_t;

  typedef struct packed {
    flags_t     fl;
    logic [1:0] neg;
  } pair_side_t;

  function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  // saturating sign-magnitude quotient, msb flags the clamp
  function automatic logic [CW:0] qsat(input logic neg, input logic big,
                                       input logic [CW-1:0] q);
    logic [CW-1:0] lim;
    logic          hit;
    lim = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    hit = big || (q > lim);
    return {hit, hit ? lim : q};
  endfunction

endpackage

// ----- hw/rtl/ppp_xform.sv -----
// ----------------------------------------------------------------------------
// ppp_xform
// Matrix store and three-stage row vector times 4x4 matrix, ending in the
// magnitudes and signs for the divide by w.
// ----------------------------------------------------------------------------
module ppp_xform (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic                                      in_func,
  input  logic [3:0]                                in_coef_index,
  input  logic signed [ppp_pkg::CW-1:0]             in_coef_value,
  input  logic signed [ppp_pkg::CW-1:0]             in_point_x,
  input  logic signed [ppp_pkg::CW-1:0]             in_point_y,
  input  logic signed [ppp_pkg::CW-1:0]             in_point_z,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [2:0][ppp_pkg::DIVB_NW-1:0]          out_num,
  output logic [ppp_pkg::CW-1:0]                    out_den,
  output ppp_pkg::tri_side_t                        out_side
);
  import ppp_pkg::*;

  localparam int PW   = 2 * CW - FB;
  localparam int SUMW = PW + 3;

  logic [CW-1:0]               tbl_r [16];
  logic                        s1_v_r, s2_v_r, s3_v_r;
  logic                        s1_adv, s2_adv, s3_adv, take;
  logic [2:0][CW-1:0]          pt;
  logic [2:0][3:0][PW-1:0]     s1_term_nxt, s1_term_r;
  logic [2:0][3:0]             s1_neg_nxt, s1_neg_r;
  logic [3:0][CW-1:0]          s1_bias_r;
  logic [3:0][CW-1:0]          s2_c_nxt, s2_c_r;
  logic                        s2_ovf_nxt, s2_ovf_r;
  logic [2:0][DIVB_NW-1:0]     s3_num_nxt, s3_num_r;
  logic [CW-1:0]               s3_den_nxt, s3_den_r;
  tri_side_t                   s3_side_nxt, s3_side_r;

  assign s3_adv   = !s3_v_r || out_ready;
  assign s2_adv   = !s2_v_r || s3_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;
  assign take     = in_valid && in_ready;
  assign pt       = {in_point_z, in_point_y, in_point_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) tbl_r[i] <= (i % 5 == 0) ? Q_ONE : '0;
    end else if (take && in_func == FUNC_COEF) begin
      tbl_r[in_coef_index] <= in_coef_value;
    end
  end

  always_comb begin
    logic [2*CW-1:0] prod;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod = (2*CW)'(mag(pt[i])) * (2*CW)'(mag(tbl_r[i*4+j]));
        s1_term_nxt[i][j] = prod[2*CW-1:FB];
        s1_neg_nxt[i][j]  = pt[i][CW-1] ^ tbl_r[i*4+j][CW-1];
      end
    end
  end

  always_comb begin
    logic [SUMW-1:0] acc, tt;
    logic            fit;
    s2_ovf_nxt = 1'b0;
    for (int j = 0; j < 4; j++) begin
      acc = {{(SUMW-CW){s1_bias_r[j][CW-1]}}, s1_bias_r[j]};
      for (int i = 0; i < 3; i++) begin
        tt  = SUMW'(s1_term_r[i][j]);
        acc = s1_neg_r[i][j] ? acc - tt : acc + tt;
      end
      fit = (&acc[SUMW-1:CW-1]) || !(|acc[SUMW-1:CW-1]);
      if (fit) begin
        s2_c_nxt[j] = acc[CW-1:0];
      end else begin
        s2_c_nxt[j] = acc[SUMW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
      s2_ovf_nxt = s2_ovf_nxt || !fit;
    end
  end

  always_comb begin
    s3_den_nxt        = mag(s2_c_r[3]);
    s3_side_nxt.fl.wz = (s2_c_r[3] == '0);
    s3_side_nxt.fl.dz = 1'b0;
    s3_side_nxt.fl.ovf = s2_ovf_r;
    for (int j = 0; j < 3; j++) begin
      s3_num_nxt[j]      = {mag(s2_c_r[j]), {FB{1'b0}}};
      s3_side_nxt.neg[j] = s2_c_r[j][CW-1] ^ s2_c_r[3][CW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_adv) s1_v_r <= take && in_func == FUNC_POINT;
      if (s2_adv) s2_v_r <= s1_v_r;
      if (s3_adv) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_term_r <= s1_term_nxt;
      s1_neg_r  <= s1_neg_nxt;
      for (int j = 0; j < 4; j++) s1_bias_r[j] <= tbl_r[12+j];
    end
    if (s2_adv) begin
      s2_c_r   <= s2_c_nxt;
      s2_ovf_r <= s2_ovf_nxt;
    end
    if (s3_adv) begin
      s3_num_r  <= s3_num_nxt;
      s3_den_r  <= s3_den_nxt;
      s3_side_r <= s3_side_nxt;
    end
  end

  assign out_valid = s3_v_r;
  assign out_num   = s3_num_r;
  assign out_den   = s3_den_r;
  assign out_side  = s3_side_r;

endmodule

// ----- hw/rtl/ppp_div.sv -----
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider, several lanes, a few quotient bits a stage,
// with a flag for quotients that do not fit and a side-band word.
// ----------------------------------------------------------------------------
module ppp_div #(
  parameter int LANES = 1,
  parameter int NW    = 48,
  parameter int DW    = 32,
  parameter int QW    = 32,
  parameter int SW    = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [LANES-1:0][NW-1:0]    in_num,
  input  logic [LANES-1:0][DW-1:0]    in_den,
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [LANES-1:0][QW-1:0]    out_quo,
  output logic [LANES-1:0][DW-1:0]    out_rem,
  output logic [LANES-1:0][DW-1:0]    out_den,
  output logic [LANES-1:0]            out_big,
  output logic [SW-1:0]               out_side
);
  import ppp_pkg::*;

  localparam int NST = QW / STEP;

  logic [NST-1:0]                 v_r, adv;
  logic [LANES-1:0][DW-1:0]       rem_r  [NST];
  logic [LANES-1:0][QW-1:0]       qn_r   [NST];
  logic [LANES-1:0][DW-1:0]       den_r  [NST];
  logic [LANES-1:0]               big_r  [NST];
  logic [SW-1:0]                  side_r [NST];

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) adv[k] = !v_r[k] || adv[k+1];
  end

  assign in_ready = adv[0];

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic [LANES-1:0][DW-1:0] src_rem, src_den, rem_nxt;
    logic [LANES-1:0][QW-1:0] src_qn, qn_nxt;
    logic [LANES-1:0]         src_big;
    logic [SW-1:0]            src_side;
    logic                     src_v;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          src_rem[l] = DW'(in_num[l][NW-1:QW]);
          src_qn[l]  = in_num[l][QW-1:0];
          src_den[l] = in_den[l];
          src_big[l] = DW'(in_num[l][NW-1:QW]) >= in_den[l];
        end
      end
      assign src_side = in_side;
      assign src_v    = in_valid;
    end else begin : g_next
      assign src_rem  = rem_r[k-1];
      assign src_qn   = qn_r[k-1];
      assign src_den  = den_r[k-1];
      assign src_big  = big_r[k-1];
      assign src_side = side_r[k-1];
      assign src_v    = v_r[k-1];
    end

    always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [QW-1:0] q;
      for (int l = 0; l < LANES; l++) begin
        r = src_rem[l];
        q = src_qn[l];
        for (int s = 0; s < STEP; s++) begin
          t = {r, q[QW-1]};
          q = {q[QW-2:0], 1'b0};
          if (t >= {1'b0, src_den[l]}) begin
            t    = t - {1'b0, src_den[l]};
            q[0] = 1'b1;
          end
          r = t[DW-1:0];
        end
        rem_nxt[l] = r;
        qn_nxt[l]  = q;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem_r[k]  <= rem_nxt;
        qn_r[k]   <= qn_nxt;
        den_r[k]  <= src_den;
        big_r[k]  <= src_big;
        side_r[k] <= src_side;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_quo   = qn_r[NST-1];
  assign out_rem   = rem_r[NST-1];
  assign out_den   = den_r[NST-1];
  assign out_big   = big_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

// ----- hw/rtl/ppp_persp.sv -----
// ----------------------------------------------------------------------------
// ppp_persp
// Clamps the divided camera vector, flags zero depth and forms the
// canvas distance products for the perspective divide.
// ----------------------------------------------------------------------------
module ppp_persp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0][ppp_pkg::CW-1:0]           in_quo,
  input  logic [2:0]                            in_big,
  input  ppp_pkg::tri_side_t                    in_side,
  input  logic [ppp_pkg::CW-1:0]                canvas_distance,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0][ppp_pkg::DIVC_NW-1:0]      out_num,
  output logic [1:0][ppp_pkg::CW-1:0]           out_den,
  output ppp_pkg::pair_side_t                   out_side
);
  import ppp_pkg::*;

  logic                    v_r, adv;
  logic [2:0][CW-1:0]      m;
  logic [2:0]              hit;
  logic [1:0][DIVC_NW-1:0] num_nxt, num_r;
  logic [1:0][CW-1:0]      den_r;
  pair_side_t              side_nxt, side_r;

  assign adv      = !v_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    for (int j = 0; j < 3; j++) {hit[j], m[j]} = qsat(in_side.neg[j], in_big[j], in_quo[j]);
    for (int j = 0; j < 2; j++) begin
      num_nxt[j]      = DIVC_NW'(m[j]) * DIVC_NW'(canvas_distance);
      side_nxt.neg[j] = in_side.neg[j] ^ !in_side.neg[2];
    end
    side_nxt.fl.wz  = in_side.fl.wz;
    side_nxt.fl.dz  = (m[2] == '0);
    side_nxt.fl.ovf = in_side.fl.ovf || (|hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r  <= num_nxt;
      den_r  <= {m[2], m[2]};
      side_r <= side_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_num   = num_r;
  assign out_den   = den_r;
  assign out_side  = side_r;

endmodule

// ----- hw/rtl/ppp_canvas.sv -----
// ----------------------------------------------------------------------------
// ppp_canvas
// Clamps the canvas coordinates and forms the numerators and divisors of
// the combined NDC and drawing area scaling.
// ----------------------------------------------------------------------------
module ppp_canvas (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0][ppp_pkg::CW-1:0]           in_quo,
  input  logic [1:0]                            in_big,
  input  ppp_pkg::pair_side_t                   in_side,
  input  logic [ppp_pkg::CW-1:0]                canv_wid,
  input  logic [ppp_pkg::CW-1:0]                canv_hgt,
  input  logic [ppp_pkg::AW-1:0]                area_width,
  input  logic [ppp_pkg::AW-1:0]                area_height,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0][ppp_pkg::DIVD_NW-1:0]      out_num,
  output logic [1:0][ppp_pkg::DIVD_DW-1:0]      out_den,
  output ppp_pkg::pair_side_t                   out_side
);
  import ppp_pkg::*;

  logic                     v_r, adv;
  logic [1:0][CW-1:0]       cws;
  logic [1:0][AW-1:0]       arw;
  logic [1:0]               hit;
  logic [1:0][DIVD_NW-1:0]  num_nxt, num_r;
  logic [1:0][DIVD_DW-1:0]  den_nxt, den_r;
  pair_side_t               side_nxt, side_r;

  assign adv      = !v_r || out_ready;
  assign in_ready = adv;
  assign cws      = {canv_hgt, canv_wid};
  assign arw      = {area_height, area_width};

  always_comb begin
    logic [CW-1:0] m, cwv;
    logic [TW-1:0] sv, t, tm;
    for (int l = 0; l < 2; l++) begin
      {hit[l], m} = qsat(in_side.neg[l], in_big[l], in_quo[l]);
      sv  = in_side.neg[l] ? -TW'(m) : TW'(m);
      cwv = (cws[l] == '0) ? CW'(1) : cws[l];
      t   = (sv << 1) + TW'(cwv);
      tm  = t[TW-1] ? -t : t;
      num_nxt[l]      = DIVD_NW'(tm[TMW-1:0]) * DIVD_NW'(arw[l]);
      den_nxt[l]      = {cwv, 1'b0};
      side_nxt.neg[l] = t[TW-1];
    end
    side_nxt.fl.wz  = in_side.fl.wz;
    side_nxt.fl.dz  = in_side.fl.dz;
    side_nxt.fl.ovf = in_side.fl.ovf || (|hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_num   = num_r;
  assign out_den   = den_r;
  assign out_side  = side_r;

endmodule

// ----- hw/rtl/perspective_point_projector_core.sv -----
// ----------------------------------------------------------------------------
// perspective_point_projector_core
// Projects Q16.16 world points through a stored 4x4 matrix to raster pixels.
// Accepts one word per cycle while out_ready does not stall it; its stages:
// three matrix stages, eight and eight divider stages for w and depth,
// five for the area scaling, three single stages between and at the end.
// Coefficient words update the matrix at once and give no result.
// Synchronous reset loads the identity matrix and the default registers.
// ----------------------------------------------------------------------------
module perspective_point_projector_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_func,
  input  logic [3:0]                             in_coef_index,
  input  logic signed [ppp_pkg::CW-1:0]          in_coef_value,
  input  logic signed [ppp_pkg::CW-1:0]          in_point_x,
  input  logic signed [ppp_pkg::CW-1:0]          in_point_y,
  input  logic signed [ppp_pkg::CW-1:0]          in_point_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ppp_pkg::RW-1:0]          out_raster_x,
  output logic signed [ppp_pkg::RW-1:0]          out_raster_y,
  output logic [1:0]                             out_status,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ppp_pkg::CFG_IW-1:0]             cfg_index,
  input  logic [ppp_pkg::CW-1:0]                 cfg_data
);
  import ppp_pkg::*;

  localparam int VW = DIVD_QW + 4;

  logic [CW-1:0] dist_r, cwid_r, chgt_r;
  logic [AW-1:0] aw_r, ah_r, ww_r, wh_r;

  logic                        xf_valid, xf_ready;
  logic [2:0][DIVB_NW-1:0]     xf_num;
  logic [CW-1:0]               xf_den;
  tri_side_t                   xf_side;

  logic                        db_valid, db_ready;
  logic [2:0][CW-1:0]          db_quo, db_rem, db_den;
  logic [2:0]                  db_big;
  tri_side_t                   db_side;

  logic                        ps_valid, ps_ready;
  logic [1:0][DIVC_NW-1:0]     ps_num;
  logic [1:0][CW-1:0]          ps_den;
  pair_side_t                  ps_side;

  logic                        dc_valid, dc_ready;
  logic [1:0][CW-1:0]          dc_quo, dc_rem, dc_den;
  logic [1:0]                  dc_big;
  pair_side_t                  dc_side;

  logic                        cv_valid, cv_ready;
  logic [1:0][DIVD_NW-1:0]     cv_num;
  logic [1:0][DIVD_DW-1:0]     cv_den;
  pair_side_t                  cv_side;

  logic                        dd_valid, dd_ready;
  logic [1:0][DIVD_QW-1:0]     dd_quo;
  logic [1:0][DIVD_DW-1:0]     dd_rem, dd_den;
  logic [1:0]                  dd_big;
  pair_side_t                  dd_side;

  logic                        o_v_r, o_adv;
  logic [1:0][RW-1:0]          pix_nxt, pix_r;
  logic [1:0]                  st_nxt, st_r;
  logic [1:0][AW-1:0]          arw, win;
  logic [1:0]                  hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= RST_DIST;
      cwid_r <= RST_CANV_W;
      chgt_r <= RST_CANV_H;
      aw_r   <= RST_AREA_W;
      ah_r   <= RST_AREA_H;
      ww_r   <= RST_WIN_W;
      wh_r   <= RST_WIN_H;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIST:   dist_r <= cfg_data;
        CFG_CANV_W: cwid_r <= cfg_data;
        CFG_CANV_H: chgt_r <= cfg_data;
        CFG_AREA_W: aw_r   <= cfg_data[AW-1:0];
        CFG_AREA_H: ah_r   <= cfg_data[AW-1:0];
        CFG_WIN_W:  ww_r   <= cfg_data[AW-1:0];
        CFG_WIN_H:  wh_r   <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  ppp_xform u_xform (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .out_valid     (xf_valid),
    .out_ready     (xf_ready),
    .out_num       (xf_num),
    .out_den       (xf_den),
    .out_side      (xf_side)
  );

  ppp_div #(
    .LANES (3),
    .NW    (DIVB_NW),
    .DW    (CW),
    .QW    (CW),
    .SW    ($bits(tri_side_t))
  ) u_div_w (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (xf_valid),
    .in_ready  (xf_ready),
    .in_num    (xf_num),
    .in_den    ({xf_den, xf_den, xf_den}),
    .in_side   (xf_side),
    .out_valid (db_valid),
    .out_ready (db_ready),
    .out_quo   (db_quo),
    .out_rem   (db_rem),
    .out_den   (db_den),
    .out_big   (db_big),
    .out_side  (db_side)
  );

  ppp_persp u_persp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (db_valid),
    .in_ready        (db_ready),
    .in_quo          (db_quo),
    .in_big          (db_big),
    .in_side         (db_side),
    .canvas_distance (dist_r),
    .out_valid       (ps_valid),
    .out_ready       (ps_ready),
    .out_num         (ps_num),
    .out_den         (ps_den),
    .out_side        (ps_side)
  );

  ppp_div #(
    .LANES (2),
    .NW    (DIVC_NW),
    .DW    (CW),
    .QW    (CW),
    .SW    ($bits(pair_side_t))
  ) u_div_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ps_valid),
    .in_ready  (ps_ready),
    .in_num    (ps_num),
    .in_den    (ps_den),
    .in_side   (ps_side),
    .out_valid (dc_valid),
    .out_ready (dc_ready),
    .out_quo   (dc_quo),
    .out_rem   (dc_rem),
    .out_den   (dc_den),
    .out_big   (dc_big),
    .out_side  (dc_side)
  );

  ppp_canvas u_canvas (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (dc_valid),
    .in_ready      (dc_ready),
    .in_quo        (dc_quo),
    .in_big        (dc_big),
    .in_side       (dc_side),
    .canv_wid      (cwid_r),
    .canv_hgt      (chgt_r),
    .area_width    (aw_r),
    .area_height   (ah_r),
    .out_valid     (cv_valid),
    .out_ready     (cv_ready),
    .out_num       (cv_num),
    .out_den       (cv_den),
    .out_side      (cv_side)
  );

  ppp_div #(
    .LANES (2),
    .NW    (DIVD_NW),
    .DW    (DIVD_DW),
    .QW    (DIVD_QW),
    .SW    ($bits(pair_side_t))
  ) u_div_area (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv_valid),
    .in_ready  (cv_ready),
    .in_num    (cv_num),
    .in_den    (cv_den),
    .in_side   (cv_side),
    .out_valid (dd_valid),
    .out_ready (dd_ready),
    .out_quo   (dd_quo),
    .out_rem   (dd_rem),
    .out_den   (dd_den),
    .out_big   (dd_big),
    .out_side  (dd_side)
  );

  // rounding, window offset and raster clamp
  assign arw = {ah_r, aw_r};
  assign win = {wh_r, ww_r};

  always_comb begin
    logic              rnd, fit;
    logic [DIVD_QW:0]  qr;
    logic [VW-1:0]     off, v;
    for (int l = 0; l < 2; l++) begin
      rnd = {dd_rem[l], 1'b0} >= {1'b0, dd_den[l]};
      qr  = (DIVD_QW+1)'(dd_quo[l]) + (DIVD_QW+1)'(rnd);
      off = dd_side.neg[l] ? -VW'(qr) : VW'(qr);
      v   = off + VW'(win[l]) - VW'(arw[l]);
      fit = (&v[VW-1:RW-1]) || !(|v[VW-1:RW-1]);
      if (dd_big[l]) begin
        hit[l]     = 1'b1;
        pix_nxt[l] = dd_side.neg[l] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
      end else if (!fit) begin
        hit[l]     = 1'b1;
        pix_nxt[l] = v[VW-1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
      end else begin
        hit[l]     = 1'b0;
        pix_nxt[l] = v[RW-1:0];
      end
    end
    if (dd_side.fl.wz) begin
      st_nxt  = ST_W_ZERO;
      pix_nxt = '0;
    end else if (dd_side.fl.dz) begin
      st_nxt  = ST_DEPTH_ZERO;
      pix_nxt = '0;
    end else if (dd_side.fl.ovf || (|hit)) begin
      st_nxt = ST_SAT;
    end else begin
      st_nxt = ST_OK;
    end
  end

  assign o_adv    = !o_v_r || out_ready;
  assign dd_ready = o_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_adv) begin
      o_v_r <= dd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv) begin
      pix_r <= pix_nxt;
      st_r  <= st_nxt;
    end
  end

  assign out_valid    = o_v_r;
  assign out_raster_x = pix_r[0];
  assign out_raster_y = pix_r[1];
  assign out_status   = st_r;

endmodule

// ----- tb/sv/perspective_point_projector_core_tb.sv -----
// ----------------------------------------------------------------------------
// perspective_point_projector_core_tb
// Self-checking bench for the point projector: a queue-fed driver offers
// coefficient and point words, a bit-exact projection model predicts each
// raster result, and a monitor compares results in order under random stalls.
// ----------------------------------------------------------------------------
module perspective_point_projector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppp_pkg::*;

  typedef struct {
    logic        func;
    logic [3:0]  idx;
    logic [31:0] cval;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } word_t;

  typedef struct {
    logic [15:0] rx;
    logic [15:0] ry;
    logic [1:0]  st;
  } pixel_t;

  localparam longint QONE = 64'sd65536;
  localparam int WATCH_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic in_func = 1'b0;
  logic [3:0] in_coef_index = '0;
  logic signed [31:0] in_coef_value = '0, in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [15:0] out_raster_x, out_raster_y;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #4 clk = ~clk;

  perspective_point_projector_core u_top (.*);

  word_t  pend_q[$];
  pixel_t pixel_q[$];
  word_t  cur_word;
  logic   in_taken = 1'b0;

  longint coef_tab[16];
  longint dist_r, canv_w_r, canv_h_r, area_w_r, area_h_r, win_w_r, win_h_r;
  bit     ovf_seen;

  int send_idle_pct = 0, recv_idle_pct = 0;
  int stall_reqs = 0, stall_served = 0, stall_left = 0;
  int errors = 0, mismatches = 0, n_points = 0, n_coefs = 0, n_results = 0, n_cfg = 0;
  int quiet_cycles = 0;
  int st_count[4] = '{0, 0, 0, 0};

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin ovf_seen = 1; return hi; end
    if (v < lo) begin ovf_seen = 1; return lo; end
    return v;
  endfunction

  function automatic longint scale_div(longint a, longint b, longint d, bit rnd);
    bit neg;
    logic [127:0] ma, mb, md, prod, q, r;
    neg = ((a < 0) != (b < 0)) != (d < 0);
    ma = {64'd0, (a < 0) ? -a : a};
    mb = {64'd0, (b < 0) ? -b : b};
    md = {64'd0, (d < 0) ? -d : d};
    prod = ma * mb;
    q = prod / md;
    r = prod % md;
    if (rnd && r >= md - r) q = q + 1;
    if (q > (128'd1 << 60)) begin
      q = 128'd1 << 60;
      ovf_seen = 1;
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint to_pixel(longint s, longint canvas, longint area, longint win);
    longint cw, off;
    cw = (canvas == 0) ? 64'sd1 : canvas;
    off = scale_div(2 * s + cw, area, 2 * cw, 1'b1);
    return clamp(off + (win - area), 16);
  endfunction

  function automatic pixel_t project(word_t w);
    pixel_t res;
    longint p[3], c[4], q[3], acc, sx, sy, rx, ry;
    rx = 0;
    ry = 0;
    ovf_seen = 0;
    p[0] = longint'($signed(w.px));
    p[1] = longint'($signed(w.py));
    p[2] = longint'($signed(w.pz));
    for (int j = 0; j < 4; j++) begin
      acc = coef_tab[12 + j];
      for (int i = 0; i < 3; i++) acc += scale_div(p[i], coef_tab[i * 4 + j], QONE, 1'b0);
      c[j] = clamp(acc, 32);
    end
    if (c[3] == 0) begin
      res.st = ST_W_ZERO;
    end else begin
      for (int j = 0; j < 3; j++) q[j] = clamp(scale_div(c[j], QONE, c[3], 1'b0), 32);
      if (q[2] == 0) begin
        res.st = ST_DEPTH_ZERO;
      end else begin
        sx = clamp(scale_div(q[0], dist_r, -q[2], 1'b0), 32);
        sy = clamp(scale_div(q[1], dist_r, -q[2], 1'b0), 32);
        rx = to_pixel(sx, canv_w_r, area_w_r, win_w_r);
        ry = to_pixel(sy, canv_h_r, area_h_r, win_h_r);
        res.st = ovf_seen ? ST_SAT : ST_OK;
      end
    end
    res.rx = rx[15:0];
    res.ry = ry[15:0];
    return res;
  endfunction

  // accept side of the input channel, prediction happens here
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      if (cur_word.func == FUNC_COEF) begin
        coef_tab[cur_word.idx] = longint'($signed(cur_word.cval));
        n_coefs++;
      end else begin
        pixel_q = {pixel_q, project(cur_word)};
        n_points++;
      end
    end
    in_taken <= in_valid && in_ready;
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_word = pend_q.pop_front();
        in_func <= cur_word.func;
        in_coef_index <= cur_word.idx;
        in_coef_value <= cur_word.cval;
        in_point_x <= cur_word.px;
        in_point_y <= cur_word.py;
        in_point_z <= cur_word.pz;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_reqs != stall_served) begin
      stall_served = stall_served + 1;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t e;
    if (out_valid && out_ready) begin
      n_results++;
      if (pixel_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result word x=%0d y=%0d st=%0d",
                                          out_raster_x, out_raster_y, out_status);
      end else begin
        e = pixel_q.pop_front();
        st_count[e.st]++;
        if (out_raster_x !== e.rx || out_raster_y !== e.ry || out_status !== e.st) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp x=%0d y=%0d st=%0d got x=%0d y=%0d st=%0d",
                     $signed(e.rx), $signed(e.ry), e.st,
                     out_raster_x, out_raster_y, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pixel_q.size());
      $display("perspective_point_projector_core verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIST:   dist_r = data;
      CFG_CANV_W: canv_w_r = data;
      CFG_CANV_H: canv_h_r = data;
      CFG_AREA_W: area_w_r = data[11:0];
      CFG_AREA_H: area_h_r = data[11:0];
      CFG_WIN_W:  win_w_r = data[11:0];
      CFG_WIN_H:  win_h_r = data[11:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || in_valid || pixel_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic word_t coef_word(int idx, logic [31:0] v);
    word_t w;
    w.func = FUNC_COEF;
    w.idx = 4'(idx);
    w.cval = v;
    w.px = $urandom;
    w.py = $urandom;
    w.pz = $urandom;
    return w;
  endfunction

  function automatic word_t point_word(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    word_t w;
    w.func = FUNC_POINT;
    w.idx = 4'($urandom);
    w.cval = $urandom;
    w.px = x;
    w.py = y;
    w.pz = z;
    return w;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(7))
      5: return 32'd0;
      6: return $urandom;
      7: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
      default: return $urandom_range(1 << 19) - (1 << 18);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord(bit depth);
    if ($urandom_range(9) == 0) return $urandom;
    if (depth) return -($urandom_range(1 << 21));
    return $urandom_range(1 << 21) - (1 << 20);
  endfunction

  task automatic load_identity();
    for (int i = 0; i < 16; i++)
      pend_q = {pend_q, coef_word(i, (i % 5 == 0) ? 32'h0001_0000 : 32'd0)};
  endtask

  initial begin
    word_t w;
    for (int i = 0; i < 16; i++) coef_tab[i] = (i % 5 == 0) ? QONE : 0;
    dist_r = RST_DIST;
    canv_w_r = RST_CANV_W;
    canv_h_r = RST_CANV_H;
    area_w_r = RST_AREA_W;
    area_h_r = RST_AREA_H;
    win_w_r = RST_WIN_W;
    win_h_r = RST_WIN_H;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words on the reset setting
    send_idle_pct = 35;
    recv_idle_pct = 64;
    pend_q = {pend_q, point_word(32'h0001_0000, 32'h0002_0000, 32'hFFFB_0000)};
    pend_q = {pend_q, point_word(32'h0003_8000, 32'hFFFE_8000, 32'h0005_0000)};
    pend_q = {pend_q, point_word(32'h0001_0000, 32'h0001_0000, 32'd0)};
    pend_q = {pend_q, point_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF)};
    pend_q = {pend_q, point_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF)};
    pend_q = {pend_q, point_word(32'd0, 32'd0, 32'h8000_0000)};
    pend_q = {pend_q, point_word(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF)};
    pend_q = {pend_q, coef_word(15, 32'd0)};
    pend_q = {pend_q, point_word(32'h0001_0000, 32'h0002_0000, 32'hFFFB_0000)};
    pend_q = {pend_q, coef_word(11, 32'hFFFF_0000)};
    pend_q = {pend_q, point_word(32'h0001_0000, 32'h0002_0000, 32'hFFFB_0000)};
    pend_q = {pend_q, coef_word(0, 32'h7FFF_FFFF)};
    pend_q = {pend_q, coef_word(5, 32'h8000_0000)};
    pend_q = {pend_q, point_word(32'h0010_0000, 32'h0010_0000, 32'hFFF0_0000)};
    pend_q = {pend_q, coef_word(14, 32'h7FFF_FFFF)};
    pend_q = {pend_q, point_word(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000)};
    load_identity();
    pend_q = {pend_q, point_word(32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_0000)};
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 64 : 0;
      recv_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 35 : 0;
      case (ph)
        0: begin
          write_reg(CFG_DIST, 32'hFFFF_FFFF);
          write_reg(CFG_CANV_W, 32'd0);
          write_reg(CFG_CANV_H, 32'd1);
          write_reg(CFG_AREA_W, 32'hFFFF_FFFF);
          write_reg(CFG_AREA_H, 32'd4095);
          write_reg(CFG_WIN_W, 32'd4095);
          write_reg(CFG_WIN_H, 32'hFFF);
          write_reg(3'd7, $urandom);
        end
        1: begin
          write_reg(CFG_DIST, 32'd0);
          write_reg(CFG_CANV_W, 32'hFFFF_FFFF);
          write_reg(CFG_CANV_H, 32'hFFFF_FFFF);
          write_reg(CFG_AREA_W, 32'd1);
          write_reg(CFG_AREA_H, 32'd0);
          write_reg(CFG_WIN_W, 32'd1);
          write_reg(CFG_WIN_H, 32'd1);
        end
        5: begin
          write_reg(CFG_DIST, RST_DIST);
          write_reg(CFG_CANV_W, RST_CANV_W);
          write_reg(CFG_CANV_H, RST_CANV_H);
          write_reg(CFG_AREA_W, RST_AREA_W);
          write_reg(CFG_AREA_H, RST_AREA_H);
          write_reg(CFG_WIN_W, RST_WIN_W);
          write_reg(CFG_WIN_H, RST_WIN_H);
        end
        default: begin
          write_reg(CFG_DIST, $urandom_range(1 << 24));
          write_reg(CFG_CANV_W, $urandom_range(1 << 24, 1));
          write_reg(CFG_CANV_H, $urandom_range(1 << 24, 1));
          write_reg(CFG_AREA_W, $urandom_range(4095, 1));
          write_reg(CFG_AREA_H, $urandom_range(4095, 1));
          write_reg(CFG_WIN_W, $urandom_range(4095, 1));
          write_reg(CFG_WIN_H, $urandom_range(4095, 1));
        end
      endcase
      if (ph == 4) stall_reqs = stall_reqs + 1;
      load_identity();
      for (int k = 0; k < 110; k++) begin
        if ($urandom_range(4) == 0)
          w = coef_word($urandom_range(15), rand_coef());
        else
          w = point_word(rand_coord(0), rand_coord(0), rand_coord($urandom_range(3) != 0));
        pend_q = {pend_q, w};
      end
      drain();
    end

    $display("covered %0d point words, %0d coefficient words, %0d register writes",
             n_points, n_coefs, n_cfg);
    $display("status mix ok=%0d w_zero=%0d depth_zero=%0d saturated=%0d, errors=%0d",
             st_count[0], st_count[1], st_count[2], st_count[3], errors);
    if (errors == 0 && pixel_q.size() == 0)
      $display("perspective_point_projector_core verification clean");
    else
      $display("perspective_point_projector_core verification failed");
    $finish;
  end

endmodule
